>>> rtl/core/esp_pkg.sv
package esp_pkg;

    // Field and register widths
    localparam int SPD_W      = 40;
    localparam int CNT_IN_W   = 32;
    localparam int TIME_IN_W  = 32;
    localparam int ALPHA_W    = 9;
    localparam int CPR_W      = 16;
    localparam int MIN_INT_W  = 20;
    localparam int STALL_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Bits retired per cycle by the serial multiplier and divider
    localparam int DIGIT_W = 3;

    // Fixed-point constants
    localparam int Q_FRAC  = 8;
    localparam int SCALE_W = 20;
    localparam logic [SCALE_W-1:0] US_PER_S = 20'd1000000;
    localparam int RPM_SCALE_W = 7;
    localparam logic [RPM_SCALE_W-1:0] RPM_SCALE = 7'd60;
    localparam int RPM_X_W = SPD_W + RPM_SCALE_W;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam logic [SPD_W-1:0] SPD_MAX     = 40'h7F_FFFF_FFFF;
    localparam logic [SPD_W-1:0] SPD_MIN     = 40'h80_0000_0000;
    localparam logic [SPD_W:0]   SPD_MAG_POS = 41'h07F_FFFF_FFFF;
    localparam logic [SPD_W:0]   SPD_MAG_NEG = 41'h080_0000_0000;

    // Register reset values
    localparam logic [ALPHA_W-1:0]   ALPHA_RST     = 9'd77;
    localparam logic [CPR_W-1:0]     CPR_RST       = 16'd1024;
    localparam logic [MIN_INT_W-1:0] MIN_INT_RST   = 20'd10000;
    localparam logic [STALL_W-1:0]   STALL_INT_RST = 24'd500000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REVERSE   = 3'd0,
        REG_ALPHA     = 3'd1,
        REG_CPR       = 3'd2,
        REG_MIN_INT   = 3'd3,
        REG_STALL_INT = 3'd4
    } esp_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUR,
        ST_DIFF,
        ST_SPD_MUL,
        ST_SPD_MUL_WAIT,
        ST_SPD_DIV,
        ST_SPD_DIV_WAIT,
        ST_RAW,
        ST_DELTA,
        ST_BLD_MUL,
        ST_BLD_MUL_WAIT,
        ST_BLEND,
        ST_STALL,
        ST_RPM_DIV,
        ST_RPM_DIV_WAIT,
        ST_DONE
    } esp_state_t;

    typedef struct packed {
        logic                        command;
        logic signed [CNT_IN_W-1:0]  count_value;
        logic [TIME_IN_W-1:0]        time_us;
    } esp_in_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] speed_q8;
        logic signed [SPD_W-1:0] rpm_q8;
        logic                    updated;
    } esp_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } esp_unit_sts_t;

endpackage

>>> rtl/core/esp_mul.sv
module esp_mul #(
    parameter int A_W = 41,
    parameter int B_W = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [A_W-1:0]         a,
    input  logic [B_W-1:0]         b,
    output logic [A_W+B_W-1:0]     product,
    output esp_pkg::esp_unit_sts_t sts
);
    import esp_pkg::*;

    localparam int STEPS = (B_W + DIGIT_W - 1) / DIGIT_W;
    localparam int BE_W  = STEPS * DIGIT_W;
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [A_W-1:0]   a_reg, a_next;
    logic [BE_W-1:0]  b_reg, b_next;
    logic [P_W-1:0]   acc_reg, acc_next, step_acc;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // MSB-first shift-add over one digit of b per cycle
    always_comb begin
        logic [P_W-1:0] acc;
        acc = acc_reg;
        for (int j = 0; j < DIGIT_W; j++) begin
            acc = {acc[P_W-2:0], 1'b0};
            if (b_reg[BE_W-1-j]) begin
                acc = acc + P_W'(a_reg);
            end
        end
        step_acc = acc;
    end

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = a;
            b_next    = BE_W'(b);
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = step_acc;
            b_next   = b_reg << DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign product  = acc_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

>>> rtl/core/esp_div.sv
module esp_div #(
    parameter int N_W = 60,
    parameter int D_W = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [N_W-1:0]         num,
    input  logic [D_W-1:0]         den,
    output logic [N_W-1:0]         quot,
    output esp_pkg::esp_unit_sts_t sts
);
    import esp_pkg::*;

    localparam int STEPS = (N_W + DIGIT_W - 1) / DIGIT_W;
    localparam int NE_W  = STEPS * DIGIT_W;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [NE_W-1:0]  q_reg, q_next, step_q;
    logic [D_W-1:0]   rem_reg, rem_next, step_rem;
    logic [D_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    // Restoring division: shift one numerator bit into the remainder, trial subtract
    always_comb begin
        logic [D_W:0]    trial;
        logic [D_W-1:0]  rem;
        logic [NE_W-1:0] q;
        rem   = rem_reg;
        q     = q_reg;
        trial = '0;
        for (int j = 0; j < DIGIT_W; j++) begin
            trial = {rem, q[NE_W-1]};
            q     = {q[NE_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial = trial - {1'b0, den_reg};
                q[0]  = 1'b1;
            end
            rem = trial[D_W-1:0];
        end
        step_q   = q;
        step_rem = rem;
    end

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = NE_W'(num);
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            q_next   = step_q;
            rem_next = step_rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot     = q_reg[N_W-1:0];
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

>>> rtl/core/encoder_speed_estimator.sv
// Encoder speed estimator.
// s_ channel: one transfer is a sample (command 0: count and microsecond time) or a
// reference load (command 1: count_value becomes the stored count).
// m_ channel: one transfer per input: filtered speed and RPM, both signed Q.8, and a
// flag set when the sample recomputed the speed.
// cfg port: single-cycle writes of direction, filter weight, counts per revolution,
// minimum interval and stall interval; write only while no item is in flight.
// Arithmetic runs on the shared serial divider (3 quotient bits per cycle, run once for
// speed and once for RPM) and the shared serial multiplier (3 multiplier bits per
// cycle, run for the 10^6 scale and the filter weight).
// Items are processed one at a time; s_ready is high only while the sequencer idles.
// The result sits in an output register, so the next item is taken while it waits;
// a stalled receiver holds the sequencer in its last step until the register frees.
// Reset clears the stored count, time and speed and loads the register defaults.
module encoder_speed_estimator #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  esp_pkg::esp_in_t                      s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output esp_pkg::esp_out_t                     m_data,
    input  logic                                  cfg_wr_en,
    input  logic [esp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [esp_pkg::CFG_DATA_W-1:0]        cfg_wr_data
);
    import esp_pkg::*;

    localparam int MUL_A_W   = (COUNT_WIDTH > SPD_W + 1) ? COUNT_WIDTH : SPD_W + 1;
    localparam int MUL_B_W   = SCALE_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SPD_NUM_W = COUNT_WIDTH + SCALE_W + Q_FRAC;
    localparam int DIV_N_W   = (SPD_NUM_W > RPM_X_W) ? SPD_NUM_W : RPM_X_W;
    localparam int DIV_D_W   = (TIME_WIDTH > CPR_W) ? TIME_WIDTH : CPR_W;
    localparam int S_W       = SPD_W + Q_FRAC + 3;

    function automatic logic [SPD_W-1:0] sat_q(input logic neg,
                                                input logic [DIV_N_W-1:0] mag);
        logic [SPD_W-1:0] res;
        if (neg) begin
            if (mag > DIV_N_W'(SPD_MAG_NEG)) begin
                res = SPD_MIN;
            end else begin
                res = ~mag[SPD_W-1:0] + 1'b1;
            end
        end else begin
            if (mag > DIV_N_W'(SPD_MAG_POS)) begin
                res = SPD_MAX;
            end else begin
                res = mag[SPD_W-1:0];
            end
        end
        return res;
    endfunction

    // Configuration registers
    logic                 rev_reg;
    logic [ALPHA_W-1:0]   alpha_reg;
    logic [CPR_W-1:0]     cpr_reg;
    logic [MIN_INT_W-1:0] min_int_reg;
    logic [STALL_W-1:0]   stall_int_reg;

    // Sequencer
    esp_state_t state_reg, state_next;
    logic       out_load;

    // Estimator state
    logic [COUNT_WIDTH-1:0] last_count_reg, last_count_next;
    logic [TIME_WIDTH-1:0]  last_time_reg, last_time_next;
    logic [SPD_W-1:0]       filtered_reg, filtered_next;
    logic                   upd_reg, upd_next;

    // Working registers
    logic                   cmd_reg, cmd_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0]  now_reg, now_next;
    logic [COUNT_WIDTH-1:0] cur_reg, cur_next;
    logic [TIME_WIDTH-1:0]  elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0] mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic                   stall_go_reg, stall_go_next;
    logic [SPD_W-1:0]       raw_reg, raw_next;
    logic                   d_neg_reg, d_neg_next;
    logic [SPD_W:0]         d_mag_reg, d_mag_next;
    logic                   rpm_neg_reg, rpm_neg_next;
    logic [SPD_W-1:0]       rpm_reg, rpm_next;

    logic     m_valid_reg, m_valid_next;
    esp_out_t m_data_reg, m_data_next;

    // Arithmetic units
    logic                 mul_start, div_start;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_product;
    esp_unit_sts_t        mul_sts, div_sts;
    logic [DIV_N_W-1:0]   div_num, div_quot;
    logic [DIV_D_W-1:0]   div_den;

    // Combinational datapath pieces
    logic [COUNT_WIDTH-1:0] cur_calc, diff_calc, mag_calc;
    logic [TIME_WIDTH-1:0]  elapsed_calc;
    logic                   upd_go;
    logic [SPD_W:0]         d_calc;
    logic [S_W-1:0]         blend_base, blend_term, blend_sum, blend_shr;
    logic                   blend_rnd;
    logic [SPD_W-1:0]       blend_res;
    logic [RPM_X_W-1:0]     rpm_x, rpm_mag;
    logic [ALPHA_W-1:0]     alpha_eff;
    logic [CPR_W-1:0]       cpr_eff;

    assign cur_calc     = rev_reg ? (~cnt_reg + 1'b1) : cnt_reg;
    assign elapsed_calc = now_reg - last_time_reg;
    assign diff_calc    = cur_reg - last_count_reg;
    assign mag_calc     = diff_calc[COUNT_WIDTH-1] ? (~diff_calc + 1'b1) : diff_calc;
    assign upd_go       = elapsed_reg > TIME_WIDTH'(min_int_reg);

    assign d_calc = {raw_reg[SPD_W-1], raw_reg} - {filtered_reg[SPD_W-1], filtered_reg};

    // old*256 + alpha*(raw - old), then divide by 256 toward zero
    assign blend_base = S_W'(signed'(filtered_reg)) << Q_FRAC;
    assign blend_term = S_W'(mul_product);
    assign blend_sum  = d_neg_reg ? (blend_base - blend_term) : (blend_base + blend_term);
    assign blend_shr  = {{Q_FRAC{blend_sum[S_W-1]}}, blend_sum[S_W-1:Q_FRAC]};
    assign blend_rnd  = blend_sum[S_W-1] && (blend_sum[Q_FRAC-1:0] != '0);
    assign blend_res  = blend_shr[SPD_W-1:0] + SPD_W'(blend_rnd);

    assign rpm_x   = RPM_X_W'(signed'(filtered_reg)) * RPM_X_W'(RPM_SCALE);
    assign rpm_mag = filtered_reg[SPD_W-1] ? (~rpm_x + 1'b1) : rpm_x;

    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign cpr_eff   = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;

    esp_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_product),
        .sts     (mul_sts)
    );

    esp_div #(
        .N_W (DIV_N_W),
        .D_W (DIV_D_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .sts     (div_sts)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_reg       <= 1'b0;
            alpha_reg     <= ALPHA_RST;
            cpr_reg       <= CPR_RST;
            min_int_reg   <= MIN_INT_RST;
            stall_int_reg <= STALL_INT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_REVERSE:   rev_reg       <= cfg_wr_data[0];
                REG_ALPHA:     alpha_reg     <= cfg_wr_data[ALPHA_W-1:0];
                REG_CPR:       cpr_reg       <= cfg_wr_data[CPR_W-1:0];
                REG_MIN_INT:   min_int_reg   <= cfg_wr_data[MIN_INT_W-1:0];
                REG_STALL_INT: stall_int_reg <= cfg_wr_data[STALL_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:         if (s_valid) state_next = ST_CUR;
            ST_CUR:          state_next = cmd_reg ? ST_RPM_DIV : ST_DIFF;
            ST_DIFF:         state_next = upd_go ? ST_SPD_MUL : ST_STALL;
            ST_SPD_MUL:      state_next = ST_SPD_MUL_WAIT;
            ST_SPD_MUL_WAIT: if (mul_sts.done) state_next = ST_SPD_DIV;
            ST_SPD_DIV:      state_next = ST_SPD_DIV_WAIT;
            ST_SPD_DIV_WAIT: if (div_sts.done) state_next = ST_RAW;
            ST_RAW:          state_next = ST_DELTA;
            ST_DELTA:        state_next = ST_BLD_MUL;
            ST_BLD_MUL:      state_next = ST_BLD_MUL_WAIT;
            ST_BLD_MUL_WAIT: if (mul_sts.done) state_next = ST_BLEND;
            ST_BLEND:        state_next = ST_STALL;
            ST_STALL:        state_next = ST_RPM_DIV;
            ST_RPM_DIV:      state_next = ST_RPM_DIV_WAIT;
            ST_RPM_DIV_WAIT: if (div_sts.done) state_next = ST_DONE;
            ST_DONE:         if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:         state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SPD_MUL: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag_reg);
                mul_b     = US_PER_S;
            end
            ST_SPD_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_N_W'({mul_product[COUNT_WIDTH+SCALE_W-1:0],
                                      {Q_FRAC{1'b0}}});
                div_den   = DIV_D_W'(elapsed_reg);
            end
            ST_BLD_MUL: begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(d_mag_reg);
                mul_b     = MUL_B_W'(alpha_eff);
            end
            ST_RPM_DIV: begin
                div_start = 1'b1;
                div_num   = DIV_N_W'(rpm_mag);
                div_den   = DIV_D_W'(cpr_eff);
            end
            ST_DONE: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // Datapath
    always_comb begin
        cmd_next        = cmd_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        cur_next        = cur_reg;
        elapsed_next    = elapsed_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        stall_go_next   = stall_go_reg;
        raw_next        = raw_reg;
        d_neg_next      = d_neg_reg;
        d_mag_next      = d_mag_reg;
        rpm_neg_next    = rpm_neg_reg;
        rpm_next        = rpm_reg;
        last_count_next = last_count_reg;
        last_time_next  = last_time_reg;
        filtered_next   = filtered_reg;
        upd_next        = upd_reg;
        m_data_next     = m_data_reg;

        if (s_valid && s_ready) begin
            cmd_next = s_data.command;
            cnt_next = s_data.count_value[COUNT_WIDTH-1:0];
            now_next = TIME_WIDTH'(s_data.time_us);
        end

        case (state_reg)
            ST_CUR: begin
                upd_next     = 1'b0;
                cur_next     = cur_calc;
                elapsed_next = elapsed_calc;
                if (cmd_reg) begin
                    last_count_next = cnt_reg;
                end
            end
            ST_DIFF: begin
                mag_next      = mag_calc;
                neg_next      = diff_calc[COUNT_WIDTH-1];
                stall_go_next = (elapsed_reg > TIME_WIDTH'(stall_int_reg))
                                && (diff_calc == '0);
            end
            ST_RAW: raw_next = sat_q(neg_reg, div_quot);
            ST_DELTA: begin
                d_neg_next = d_calc[SPD_W];
                d_mag_next = d_calc[SPD_W] ? (~d_calc + 1'b1) : d_calc;
            end
            ST_BLEND: begin
                filtered_next   = blend_res;
                last_count_next = cur_reg;
                last_time_next  = now_reg;
                upd_next        = 1'b1;
            end
            ST_STALL: begin
                // stall check uses the interval and difference from before the blend
                if (stall_go_reg) begin
                    filtered_next  = '0;
                    last_time_next = now_reg;
                end
            end
            ST_RPM_DIV: rpm_neg_next = filtered_reg[SPD_W-1];
            ST_RPM_DIV_WAIT: begin
                if (div_sts.done) begin
                    rpm_next = sat_q(rpm_neg_reg, div_quot);
                end
            end
            default: ;
        endcase

        if (out_load) begin
            m_data_next.speed_q8 = filtered_reg;
            m_data_next.rpm_q8   = rpm_reg;
            m_data_next.updated  = upd_reg;
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            last_count_reg <= '0;
            last_time_reg  <= '0;
            filtered_reg   <= '0;
            upd_reg        <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            last_count_reg <= last_count_next;
            last_time_reg  <= last_time_next;
            filtered_reg   <= filtered_next;
            upd_reg        <= upd_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        cnt_reg      <= cnt_next;
        now_reg      <= now_next;
        cur_reg      <= cur_next;
        elapsed_reg  <= elapsed_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        stall_go_reg <= stall_go_next;
        raw_reg      <= raw_next;
        d_neg_reg    <= d_neg_next;
        d_mag_reg    <= d_mag_next;
        rpm_neg_reg  <= rpm_neg_next;
        rpm_reg      <= rpm_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_mul_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier started while busy");

    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_sts.done |-> (state_reg == ST_SPD_DIV_WAIT || state_reg == ST_RPM_DIV_WAIT))
        else $error("divider finished outside a wait step");

    a_stall_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STALL && stall_go_reg) |=> (filtered_reg == '0))
        else $error("stall did not clear the speed");

    a_load_sets_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CUR && cmd_reg) |=> (last_count_reg == $past(cnt_reg)))
        else $error("reference load did not update the stored count");

    a_result_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && m_data.updated == $past(upd_reg)))
        else $error("result register not loaded");

endmodule
